>>> rtl/base64url_stream_codec_unit_assert.svh
// Assertion macros shared by the codec modules.
`ifndef BASE64URL_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64URL_STREAM_CODEC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define B64U_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("codec assertion failed (same cycle)");

// Next-cycle implication, disabled while rst is high.
`define B64U_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("codec assertion failed (next cycle)");

`endif

>>> rtl/b64u_pkg.sv
`timescale 1ns / 1ps

package b64u_pkg;

   // Default depth of the group queue between front and back.
   localparam int unsigned QueueDepth = 2;

   localparam logic [7:0] PadChar   = 8'h3D;
   localparam logic [7:0] DashChar  = 8'h2D;
   localparam logic [7:0] UnderChar = 8'h5F;

   typedef enum logic {
      MODE_ENCODE,
      MODE_DECODE
   } mode_type;

   // What the back end has to do with one queued group.
   typedef enum logic [1:0] {
      GRP_ENCODE,
      GRP_DECODE,
      GRP_ERROR
   } grp_kind_type;

   typedef struct packed {
      grp_kind_type    kind;
      logic [3:0][7:0] items;   // items[0] is the first word of the group
      logic [1:0]      nbytes;  // encode only: 1 to 3 real bytes
      logic            last;
   } grp_cmd_type;

   // Six-bit value to its URL-safe character.
   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = DashChar;
      end else begin
         c = UnderChar;
      end
      return c;
   endfunction

   // Character to {valid, six-bit value}; valid is low outside the alphabet.
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [6:0] r;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == DashChar) begin
         r = {1'b1, 6'd62};
      end else if (c == UnderChar) begin
         r = {1'b1, 6'd63};
      end else begin
         r = 7'd0;
      end
      return r;
   endfunction

endpackage

>>> rtl/base64url_stream_codec_unit.sv
// A closed group passes through the group queue, then the group register, and its first
// result word through the output register; a busy group register or low rsp_ready stalls.
// Throughput: one input word per cycle into a group queue while it has room; the back
// end sends one result word per cycle while the consumer keeps up. Encoding is limited
// by the output serializer, decoding by the input side. Reset (synchronous, active high)
// clears the mode to encode, the group count, the queue and the back end's valid flags.
`timescale 1ns / 1ps

module base64url_stream_codec_unit import b64u_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out,
   output logic       rsp_length_error
);

   logic        queue_full;
   logic        push;
   logic        pop;
   logic        head_valid;
   grp_cmd_type push_cmd;
   grp_cmd_type head_cmd;

   // Front end: mode register and group gathering.
   b64u_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .queue_full       (queue_full),
      .push             (push),
      .cmd              (push_cmd)
   );

   // Group queue between the two halves.
   b64u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back end: conversion and result serializer.
   b64u_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_out     (rsp_last_out),
      .rsp_length_error (rsp_length_error)
   );

endmodule

>>> rtl/b64u_front.sv
`timescale 1ns / 1ps

module b64u_front import b64u_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        queue_full,
   output logic        push,
   output grp_cmd_type cmd
);

   mode_type   mode_ff;
   logic [1:0] count_ff, count_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic       accept;

   // A word is taken whenever the queue has room for the group it may close.
   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else if (csr_write_enable) begin
         mode_ff <= mode_type'(csr_write_data);
      end
   end

   // Gather words into groups and hand closed groups to the queue.
   always_comb begin
      count_in   = count_ff;
      held_in    = held_ff;
      push       = 1'b0;
      cmd        = '0;
      cmd.kind   = GRP_ENCODE;
      cmd.last   = req_last;
      if (accept) begin
         if (mode_ff == MODE_ENCODE) begin
            if (count_ff < 2'd2 && !req_last) begin
               held_in[count_ff] = req_data_byte;
               count_in          = count_ff + 2'd1;
            end else begin
               push     = 1'b1;
               count_in = 2'd0;
               if (count_ff >= 2'd2) begin
                  cmd.items  = {8'd0, req_data_byte, held_ff[1], held_ff[0]};
                  cmd.nbytes = 2'd3;
               end else if (count_ff == 2'd1) begin
                  cmd.items  = {8'd0, 8'd0, req_data_byte, held_ff[0]};
                  cmd.nbytes = 2'd2;
               end else begin
                  cmd.items  = {8'd0, 8'd0, 8'd0, req_data_byte};
                  cmd.nbytes = 2'd1;
               end
            end
         end else begin
            if (count_ff < 2'd3) begin
               if (req_last) begin
                  // Short final group: one error word, the group is dropped.
                  push     = 1'b1;
                  cmd.kind = GRP_ERROR;
                  count_in = 2'd0;
               end else begin
                  held_in[count_ff] = req_data_byte;
                  count_in          = count_ff + 2'd1;
               end
            end else begin
               push      = 1'b1;
               cmd.kind  = GRP_DECODE;
               cmd.items = {req_data_byte, held_ff[2], held_ff[1], held_ff[0]};
               count_in  = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

>>> rtl/b64u_queue.sv
`timescale 1ns / 1ps
`include "base64url_stream_codec_unit_assert.svh"

module b64u_queue import b64u_pkg::*; #(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  grp_cmd_type push_cmd,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output grp_cmd_type head_cmd
);

   localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(DEPTH - 1);

   grp_cmd_type         entry_ff [DEPTH];
   logic [IdxWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full       = (count_ff == CntWidth'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // The front never pushes into a full queue and the back never pops an empty one.
   `B64U_ASSERT_IMPLIES(a_no_overflow, clock, reset, push, !full)
   `B64U_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, head_valid)

endmodule

>>> rtl/b64u_back.sv
`timescale 1ns / 1ps
`include "base64url_stream_codec_unit_assert.svh"

module b64u_back import b64u_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  grp_cmd_type head_cmd,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_out,
   output logic        rsp_length_error
);

   // Group being serialized.
   logic            grp_valid_ff;
   logic [3:0][7:0] grp_words_ff;
   logic [1:0]      grp_idx_ff;
   logic [1:0]      grp_last_idx_ff;
   logic            grp_last_ff;
   logic            grp_err_ff;

   // Output register.
   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;
   logic            rsp_err_ff;

   // Expanded head of the queue.
   logic [3:0][7:0] exp_words;
   logic [1:0]      exp_last_idx;
   logic            exp_err;
   logic [6:0]      dec0, dec1, dec2, dec3;
   logic [5:0]      s0, s1, s2, s3;
   logic            pad2, pad3;

   logic            out_free;
   logic            emit;
   logic            grp_done;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = grp_valid_ff && out_free;
   assign grp_done = emit && (grp_idx_ff == grp_last_idx_ff);
   assign pop      = head_valid && (!grp_valid_ff || grp_done);

   // Turn the queued group into the words it produces.
   always_comb begin
      exp_words    = '0;
      exp_last_idx = 2'd0;
      exp_err      = 1'b0;
      s0           = head_cmd.items[0][7:2];
      s1           = {head_cmd.items[0][1:0], head_cmd.items[1][7:4]};
      s2           = {head_cmd.items[1][3:0], head_cmd.items[2][7:6]};
      s3           = head_cmd.items[2][5:0];
      dec0         = char_to_sextet(head_cmd.items[0]);
      dec1         = char_to_sextet(head_cmd.items[1]);
      dec2         = char_to_sextet(head_cmd.items[2]);
      dec3         = char_to_sextet(head_cmd.items[3]);
      pad2         = (head_cmd.items[2] == PadChar);
      pad3         = (head_cmd.items[3] == PadChar);
      unique case (head_cmd.kind)
         GRP_ENCODE: begin
            exp_words[0] = sextet_to_char(s0);
            exp_words[1] = sextet_to_char(s1);
            exp_words[2] = (head_cmd.nbytes >= 2'd2) ? sextet_to_char(s2) : PadChar;
            exp_words[3] = (head_cmd.nbytes == 2'd3) ? sextet_to_char(s3) : PadChar;
            exp_last_idx = 2'd3;
         end
         GRP_DECODE: begin
            // Padding zeroes the covered places; any bad character zeroes the group.
            if (pad3 && pad2) begin
               if (dec0[6] && dec1[6]) begin
                  exp_words[0] = {dec0[5:0], dec1[5:4]};
               end
            end else if (pad3) begin
               if (dec0[6] && dec1[6] && dec2[6]) begin
                  exp_words[0] = {dec0[5:0], dec1[5:4]};
                  exp_words[1] = {dec1[3:0], dec2[5:2]};
               end
            end else if (dec0[6] && dec1[6] && dec2[6] && dec3[6]) begin
               exp_words[0] = {dec0[5:0], dec1[5:4]};
               exp_words[1] = {dec1[3:0], dec2[5:2]};
               exp_words[2] = {dec2[1:0], dec3[5:0]};
            end
            // Only a final group is shortened by its padding.
            if (head_cmd.last && pad3) begin
               exp_last_idx = pad2 ? 2'd0 : 2'd1;
            end else begin
               exp_last_idx = 2'd2;
            end
         end
         GRP_ERROR: begin
            exp_err = 1'b1;
         end
         default: begin
            exp_err = 1'b1;
         end
      endcase
   end

   // Group register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= 2'd0;
      end else if (pop) begin
         grp_valid_ff <= 1'b1;
         grp_idx_ff   <= 2'd0;
      end else if (grp_done) begin
         grp_valid_ff <= 1'b0;
      end else if (emit) begin
         grp_idx_ff <= grp_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         grp_words_ff    <= exp_words;
         grp_last_idx_ff <= exp_last_idx;
         grp_last_ff     <= head_cmd.last;
         grp_err_ff      <= exp_err;
      end
   end

   // Output register: one word per cycle while the consumer keeps up.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= grp_words_ff[grp_idx_ff];
         rsp_last_ff <= grp_last_ff && (grp_idx_ff == grp_last_idx_ff);
         rsp_err_ff  <= grp_err_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_length_error = rsp_err_ff;

   // An error word is always a zero byte that closes the message.
   `B64U_ASSERT_IMPLIES(a_err_form, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_last_ff && rsp_byte_ff == 8'd0)
   // The word index never runs past the group's last word.
   `B64U_ASSERT_IMPLIES(a_idx_range, clock, reset, grp_valid_ff, grp_idx_ff <= grp_last_idx_ff)
   // Reset leaves nothing pending on the output side.
   `B64U_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid_ff && !grp_valid_ff)

endmodule

>>> tb/b64u_tb_pkg.sv
`timescale 1ns / 1ps

package b64u_tb_pkg;
   import b64u_pkg::*;

   // One result word as the codec should present it.
   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       length_error;
   } codec_word_type;

   // Tracks the codec state, predicts the result words of each accepted input word,
   // and checks the result words that come out against them in order.
   class b64u_word_tracker;
      int unsigned    errors;
      string          alphabet;
      mode_type       mode_now;
      logic [1:0]     fill;
      logic [7:0]     held [3];
      codec_word_type expected_words [$];

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
         errors   = 0;
         mode_now = MODE_ENCODE;
         fill     = 2'd0;
         foreach (held[i]) held[i] = 8'h00;
      endfunction

      function void write_mode(mode_type m);
         mode_now = m;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function logic [7:0] url_char(logic [5:0] v);
         return alphabet[int'(v)];
      endfunction

      // Looks a character up in the URL-safe alphabet; returns 0 when it is not there.
      function bit url_value(input logic [7:0] c, output logic [5:0] v);
         v = 6'd0;
         for (int i = 0; i < 64; i++) begin
            if (alphabet[i] == c) begin
               v = 6'(i);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void push(logic [7:0] v, logic l, logic e);
         codec_word_type w;
         w.value        = v;
         w.last         = l;
         w.length_error = e;
         expected_words.push_back(w);
      endfunction

      // Notes one accepted input word and queues the result words it causes.
      function void take_input(logic [7:0] d, logic l);
         logic [23:0] bits;
         logic [5:0]  sx [4];
         logic [7:0]  chars [4];
         logic [7:0]  grp [4];
         logic [7:0]  bytes_out [3];
         bit          ok [4];
         int unsigned nbytes;
         int unsigned count;
         if (mode_now == MODE_ENCODE) begin
            // Bytes are held until a group of three is complete or the message ends.
            if (fill < 2'd2 && !l) begin
               held[fill] = d;
               fill++;
               return;
            end
            case (fill)
               2'd0: begin
                  bits   = {d, 16'h0000};
                  nbytes = 1;
               end
               2'd1: begin
                  bits   = {held[0], d, 8'h00};
                  nbytes = 2;
               end
               default: begin
                  bits   = {held[0], held[1], d};
                  nbytes = 3;
               end
            endcase
            fill = 2'd0;
            for (int k = 0; k < 4; k++) chars[k] = url_char(bits[23 - 6 * k -: 6]);
            if (nbytes < 2) chars[2] = PadChar;
            if (nbytes < 3) chars[3] = PadChar;
            for (int k = 0; k < 4; k++) push(chars[k], l && k == 3, 1'b0);
         end else begin
            // A message that ends inside a group gives one error word and drops the group.
            if (fill < 2'd3) begin
               if (l) begin
                  fill = 2'd0;
                  push(8'h00, 1'b1, 1'b1);
                  return;
               end
               held[fill] = d;
               fill++;
               return;
            end
            grp  = '{held[0], held[1], held[2], d};
            fill = 2'd0;
            for (int k = 0; k < 4; k++) ok[k] = url_value(grp[k], sx[k]);
            bits      = {sx[0], sx[1], sx[2], sx[3]};
            bytes_out = '{8'h00, 8'h00, 8'h00};
            // Any character outside the alphabet zeroes the whole group; a lone '=' in
            // the third place is such a character.
            if (grp[3] == PadChar && grp[2] == PadChar) begin
               if (ok[0] && ok[1]) bytes_out[0] = bits[23:16];
            end else if (grp[3] == PadChar) begin
               if (ok[0] && ok[1] && ok[2]) begin
                  bytes_out[0] = bits[23:16];
                  bytes_out[1] = bits[15:8];
               end
            end else if (ok[0] && ok[1] && ok[2] && ok[3]) begin
               bytes_out[0] = bits[23:16];
               bytes_out[1] = bits[15:8];
               bytes_out[2] = bits[7:0];
            end
            // Padding shortens only the final group; in mid-stream it gives zero bytes.
            count = 3;
            if (l && grp[3] == PadChar) count = (grp[2] == PadChar) ? 1 : 2;
            for (int k = 0; k < count; k++) push(bytes_out[k], l && k == count - 1, 1'b0);
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compares one result word with the oldest prediction.
      task check_output(logic [7:0] v, logic l, logic e);
         codec_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("result word 0x%02h last=%0b error=%0b with none expected",
                             v, l, e));
            return;
         end
         want = expected_words.pop_front();
         if (v !== want.value) begin
            report($sformatf("out_byte 0x%02h, expected 0x%02h", v, want.value));
         end
         if (l !== want.last) begin
            report($sformatf("last_out %0b, expected %0b", l, want.last));
         end
         if (e !== want.length_error) begin
            report($sformatf("length_error %0b, expected %0b", e, want.length_error));
         end
      endtask
   endclass

endpackage

>>> tb/base64url_stream_codec_unit_test.sv
`timescale 1ns / 1ps

module base64url_stream_codec_unit_test;
   import b64u_pkg::*;
   import b64u_tb_pkg::*;

   localparam int SettleCycles = 12;
   localparam int RandomItems  = 480;
   localparam int Phases       = 6;
   localparam int IdlePercent  = 13;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data   = 1'b0;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte    = 8'h00;
   logic       req_last         = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_out;
   logic       rsp_length_error;

   // While quiet is set neither side idles.
   bit                quiet      = 1'b0;
   int unsigned       words_sent = 0;
   b64u_word_tracker  tracker;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   base64url_stream_codec_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_out     (rsp_last_out),
      .rsp_length_error (rsp_length_error)
   );

   // The receiver stalls at random except in the quiet stretch.
   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IdlePercent);
   end

   // Every result word taken at a rising edge is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_output(rsp_out_byte, rsp_last_out, rsp_length_error);
      end
   end

   // Presents one input word, with random idle cycles ahead of it, and waits until it
   // is taken. Returns at the next falling edge with valid still high.
   task automatic send_word(input logic [7:0] d, input logic l);
      while (!quiet && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last      <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_input(d, l);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit end_message);
      for (int i = 0; i < s.len(); i++) send_word(s[i], end_message && i == s.len() - 1);
   endtask

   // Stops sending and waits until every predicted word has come out, plus a margin
   // for groups still inside the block that cause no result.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_mode(input mode_type m);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(negedge clock);
      tracker.write_mode(m);
      csr_write_enable <= 1'b0;
   endtask

   // A random message of raw bytes, or now and then a stray byte with no end mark.
   task automatic send_encode_message();
      int unsigned len;
      len = $urandom_range(1, 9);
      if ($urandom_range(99) < 5) begin
         send_word(8'($urandom), 1'b0);
      end else begin
         for (int i = 0; i < len; i++) send_word(8'($urandom), i == len - 1);
      end
   endtask

   // Mostly well-formed text; the rest is broken text and single noise words.
   task automatic send_decode_message();
      int unsigned pick;
      int unsigned groups;
      int unsigned pads;
      int unsigned len;
      logic [7:0]  c;
      pick = $urandom_range(99);
      if (pick < 80) begin
         // Full groups, a padded one in mid-stream now and then, and an end with zero to two pads.
         groups = $urandom_range(1, 4);
         for (int g = 0; g < groups; g++) begin
            pads = (g == groups - 1 || $urandom_range(9) == 0) ? $urandom_range(2) : 0;
            for (int k = 0; k < 4; k++) begin
               c = (k >= 4 - pads) ? PadChar : tracker.url_char(6'($urandom));
               send_word(c, g == groups - 1 && k == 3);
            end
         end
      end else if (pick < 92) begin
         // Wrong lengths, stray padding and characters outside the alphabet.
         len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(3))
               0: begin
                  c = PadChar;
               end
               1: begin
                  c = 8'($urandom);
               end
               default: begin
                  c = tracker.url_char(6'($urandom));
               end
            endcase
            send_word(c, i == len - 1);
         end
      end else begin
         send_word(8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int unsigned target;
      bit          paused;
      paused  = 1'b0;
      tracker = new();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Encode: extreme bytes, the '-' and '_' characters, and both short final groups.
      set_mode(MODE_ENCODE);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFB, 1'b0);
      send_word(8'hEF, 1'b1);
      send_word(8'h80, 1'b1);

      // Decode: a padded group in mid-stream, a character outside the alphabet,
      // '=' in the third place alone, a doubly padded end and a message cut short.
      set_mode(MODE_DECODE);
      send_text("_-A=", 1'b0);
      send_text("Q!JD", 1'b0);
      send_text("QU=D", 1'b1);
      send_text("AA==", 1'b1);
      send_text("Q", 1'b1);

      // A mode change with three characters held: encode uses only the first two.
      send_text("QUJ", 1'b0);
      set_mode(MODE_ENCODE);
      send_word(8'h44, 1'b1);

      // Random phases in alternating modes; the third runs with no idling at all.
      for (int phase = 0; phase < Phases; phase++) begin
         set_mode((phase % 2 == 0) ? MODE_DECODE : MODE_ENCODE);
         quiet  <= (phase == 2);
         target = words_sent + RandomItems / Phases;
         while (words_sent < target) begin
            if (phase == 3 && !paused && words_sent + 40 >= target) begin
               wait_drained();
               paused = 1'b1;
            end
            if (phase % 2 == 0) begin
               send_decode_message();
            end else begin
               send_encode_message();
            end
         end
      end
      quiet <= 1'b0;

      wait_drained();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
